>>> hdl/tki_pkg.sv
package tki_pkg;

  localparam int unsigned ListSizeDefault = 64;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned IdxW = 6;
  localparam int unsigned ReadReach = 64;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // What one cell hands to the next one down the list
  typedef struct packed {
    logic                ge;
    logic [ScoreW-1:0]   score;
    logic [PayloadW-1:0] payload;
  } cell_link_t;

endpackage

>>> hdl/tki_cell.sv
module tki_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ins_en_i,
  input  logic [tki_pkg::ScoreW-1:0]    new_score_i,
  input  logic [tki_pkg::PayloadW-1:0]  new_payload_i,
  input  tki_pkg::cell_link_t           prev_i,
  output tki_pkg::cell_link_t           next_o,
  output logic                          take_new_o
);

  logic [tki_pkg::ScoreW-1:0]   score_q;
  logic [tki_pkg::PayloadW-1:0] payload_q;
  logic                         ge;

  assign ge         = score_q >= new_score_i;
  // Insertion point: everything above holds a score at least as large
  assign take_new_o = prev_i.ge && !ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q   <= '0;
      payload_q <= '0;
    end else if (ins_en_i) begin
      if (take_new_o) begin
        score_q   <= new_score_i;
        payload_q <= new_payload_i;
      end else if (!ge) begin
        score_q   <= prev_i.score;
        payload_q <= prev_i.payload;
      end
    end
  end

  assign next_o.ge      = ge;
  assign next_o.score   = score_q;
  assign next_o.payload = payload_q;

endmodule

>>> hdl/tki_chain.sv
module tki_chain #(
  parameter int unsigned ListSize = tki_pkg::ListSizeDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ins_en_i,
  input  logic [tki_pkg::ScoreW-1:0]    new_score_i,
  input  logic [tki_pkg::PayloadW-1:0]  new_payload_i,
  input  logic [tki_pkg::IdxW-1:0]      read_index_i,
  output logic [ListSize-1:0]           slot_mask_o,
  output logic                          last_ge_o,
  output logic [tki_pkg::ScoreW-1:0]    last_score_o,
  output logic [tki_pkg::ScoreW-1:0]    rd_score_o,
  output logic [tki_pkg::PayloadW-1:0]  rd_payload_o
);

  localparam int unsigned ReadSpan =
    (ListSize < tki_pkg::ReadReach) ? ListSize : tki_pkg::ReadReach;

  tki_pkg::cell_link_t links [ListSize+1];

  // Head of the list: a virtual entry that beats every score
  assign links[0].ge      = 1'b1;
  assign links[0].score   = '0;
  assign links[0].payload = '0;

  for (genvar g = 0; g < ListSize; g++) begin : g_cell
    tki_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ins_en_i      (ins_en_i),
      .new_score_i   (new_score_i),
      .new_payload_i (new_payload_i),
      .prev_i        (links[g]),
      .next_o        (links[g+1]),
      .take_new_o    (slot_mask_o[g])
    );
  end

  assign last_ge_o    = links[ListSize].ge;
  assign last_score_o = links[ListSize].score;

  always_comb begin
    rd_score_o   = '0;
    rd_payload_o = '0;
    for (int i = 0; i < ReadSpan; i++) begin
      if (read_index_i == tki_pkg::IdxW'(i)) begin
        rd_score_o   = links[i+1].score;
        rd_payload_o = links[i+1].payload;
      end
    end
  end

endmodule

>>> hdl/top_k_sorted_insert_unit.sv
// A request shifts the chain as it is accepted; its one-hot slot mask is registered
// in mask_q, encoded to a position and loaded into the output register once that
// register is free. The input stays stalled while the encode is pending, so no new
// request is taken until the last one has moved to the output register. A stalled
// result lets one further request in, then the input stalls until the result is taken.
// Reset clears every cell to a zero score and zero payload at once.
module top_k_sorted_insert_unit #(
  parameter int unsigned ListSize = tki_pkg::ListSizeDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [tki_pkg::ScoreW-1:0]    score_i,
  input  logic [tki_pkg::PayloadW-1:0]  payload_i,
  input  logic [tki_pkg::IdxW-1:0]      read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [tki_pkg::IdxW-1:0]      insert_position_o,
  output logic [tki_pkg::ScoreW-1:0]    entry_score_o,
  output logic [tki_pkg::PayloadW-1:0]  entry_payload_o,
  output logic [tki_pkg::ScoreW-1:0]    cutoff_score_o
);

  logic                         in_acc;
  logic                         is_ins;
  logic                         ins_en;
  logic                         last_ge;
  logic [ListSize-1:0]          slot_mask;
  logic [tki_pkg::ScoreW-1:0]   last_score;
  logic [tki_pkg::ScoreW-1:0]   rd_score;
  logic [tki_pkg::PayloadW-1:0] rd_payload;

  logic                         pend_q;
  logic [ListSize-1:0]          mask_q;
  logic                         acc_q;
  logic [tki_pkg::ScoreW-1:0]   rd_score_q;
  logic [tki_pkg::PayloadW-1:0] rd_payload_q;
  logic [tki_pkg::IdxW-1:0]     pos;
  logic                         out_load;
  logic                         out_valid_q;
  logic                         accepted_q;
  logic [tki_pkg::IdxW-1:0]     position_q;
  logic [tki_pkg::ScoreW-1:0]   entry_score_q;
  logic [tki_pkg::PayloadW-1:0] entry_payload_q;
  logic [tki_pkg::ScoreW-1:0]   cutoff_q;

  assign in_stall_o = pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_ins     = operation_i == tki_pkg::OP_INSERT;
  assign ins_en     = in_acc && is_ins && !last_ge;

  tki_chain #(
    .ListSize (ListSize)
  ) u_chain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ins_en_i      (ins_en),
    .new_score_i   (score_i),
    .new_payload_i (payload_i),
    .read_index_i  (read_index_i),
    .slot_mask_o   (slot_mask),
    .last_ge_o     (last_ge),
    .last_score_o  (last_score),
    .rd_score_o    (rd_score),
    .rd_payload_o  (rd_payload)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (in_acc) begin
      pend_q <= 1'b1;
    end else if (out_load) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mask_q       <= ins_en ? slot_mask : '0;
      acc_q        <= ins_en;
      rd_score_q   <= is_ins ? '0 : rd_score;
      rd_payload_q <= is_ins ? '0 : rd_payload;
    end
  end

  // One-hot slot to position, kept modulo 64
  always_comb begin
    pos = '0;
    for (int i = 0; i < ListSize; i++) begin
      pos = pos | (mask_q[i] ? tki_pkg::IdxW'(i) : '0);
    end
  end

  assign out_load = pend_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      accepted_q      <= acc_q;
      position_q      <= pos;
      entry_score_q   <= rd_score_q;
      entry_payload_q <= rd_payload_q;
      cutoff_q        <= last_score;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign insert_position_o = position_q;
  assign entry_score_o     = entry_score_q;
  assign entry_payload_o   = entry_payload_q;
  assign cutoff_score_o    = cutoff_q;

endmodule

>>> hdl/tki_checker.sv
module tki_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          accepted_o,
  input logic [tki_pkg::IdxW-1:0]      insert_position_o,
  input logic [tki_pkg::ScoreW-1:0]    entry_score_o,
  input logic [tki_pkg::PayloadW-1:0]  entry_payload_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Each request is followed by a cycle in which no further request is taken
  a_stall_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken during slot encode");

  a_reject_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> insert_position_o == '0)
    else $error("position reported on a rejected or read request");

  a_insert_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> entry_score_o == '0 && entry_payload_o == '0)
    else $error("entry data reported on an insert");

endmodule

bind top_k_sorted_insert_unit tki_checker u_tki_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .accepted_o        (accepted_o),
  .insert_position_o (insert_position_o),
  .entry_score_o     (entry_score_o),
  .entry_payload_o   (entry_payload_o)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ListSize = tki_pkg::ListSizeDefault;
  localparam int unsigned ScoreW = tki_pkg::ScoreW;
  localparam int unsigned PayloadW = tki_pkg::PayloadW;
  localparam int unsigned IdxW = tki_pkg::IdxW;
  localparam int unsigned RandomItems = 430;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit = 2000;

  // Tracks the best-score list and the results it should produce, in order
  class top_list_board;
    typedef struct {
      logic                accepted;
      logic [IdxW-1:0]     position;
      logic [ScoreW-1:0]   entry_score;
      logic [PayloadW-1:0] entry_payload;
      logic [ScoreW-1:0]   cutoff;
    } list_result_t;

    logic [ScoreW-1:0]   scores[ListSize];
    logic [PayloadW-1:0] payloads[ListSize];
    list_result_t        awaited[$];
    int unsigned         errors;

    function new();
      foreach (scores[i]) begin
        scores[i] = '0;
        payloads[i] = '0;
      end
      errors = 0;
    endfunction

    function logic [ScoreW-1:0] cutoff();
      return scores[ListSize-1];
    endfunction

    function logic [ScoreW-1:0] score_at(int unsigned idx);
      return scores[idx];
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_request(tki_pkg::op_e op, logic [ScoreW-1:0] score,
                               logic [PayloadW-1:0] payload, logic [IdxW-1:0] idx);
      list_result_t r;
      int unsigned  slot;
      r = '{default: '0};
      if (op == tki_pkg::OP_INSERT) begin
        if (score > scores[ListSize-1]) begin
          // new entry goes below every entry of equal or higher score
          slot = 0;
          foreach (scores[i]) if (scores[i] >= score) slot++;
          for (int i = ListSize - 1; i > int'(slot); i--) begin
            scores[i] = scores[i-1];
            payloads[i] = payloads[i-1];
          end
          scores[slot] = score;
          payloads[slot] = payload;
          r.accepted = 1'b1;
          r.position = slot[IdxW-1:0];
        end
      end else if (idx < ListSize) begin
        r.entry_score = scores[idx];
        r.entry_payload = payloads[idx];
      end
      r.cutoff = scores[ListSize-1];
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [PayloadW-1:0] exp_val,
                                logic [PayloadW-1:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    function void check_result(logic accepted, logic [IdxW-1:0] position,
                               logic [ScoreW-1:0] entry_score,
                               logic [PayloadW-1:0] entry_payload,
                               logic [ScoreW-1:0] cutoff_score);
      list_result_t r;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual accepted=%0b pos=%0d",
                 $time, accepted, position);
        errors++;
        return;
      end
      r = awaited.pop_front();
      compare_field("accepted", PayloadW'(r.accepted), PayloadW'(accepted));
      compare_field("insert_position", PayloadW'(r.position), PayloadW'(position));
      compare_field("entry_score", PayloadW'(r.entry_score), PayloadW'(entry_score));
      compare_field("entry_payload", r.entry_payload, entry_payload);
      compare_field("cutoff_score", PayloadW'(r.cutoff), PayloadW'(cutoff_score));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                operation_i = 1'b0;
  logic [ScoreW-1:0]   score_i = '0;
  logic [PayloadW-1:0] payload_i = '0;
  logic [IdxW-1:0]     read_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                accepted_o;
  logic [IdxW-1:0]     insert_position_o;
  logic [ScoreW-1:0]   entry_score_o;
  logic [PayloadW-1:0] entry_payload_o;
  logic [ScoreW-1:0]   cutoff_score_o;

  top_list_board board = new();
  bit                no_idle = 1'b0;
  bit                hold_output = 1'b0;
  int unsigned       idle_cycles = 0;

  top_k_sorted_insert_unit #(
    .ListSize(ListSize)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .operation_i(operation_i),
    .score_i(score_i),
    .payload_i(payload_i),
    .read_index_i(read_index_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .accepted_o(accepted_o),
    .insert_position_o(insert_position_o),
    .entry_score_o(entry_score_o),
    .entry_payload_o(entry_payload_o),
    .cutoff_score_o(cutoff_score_o)
  );

  always #1 clk_i = ~clk_i;

  // results are checked before the same-edge request is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_result(accepted_o, insert_position_o, entry_score_o,
                           entry_payload_o, cutoff_score_o);
      end
      if (in_valid_i && !in_stall_o) begin
        board.note_request(tki_pkg::op_e'(operation_i), score_i, payload_i,
                           read_index_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall before each result, plus one long hold-off
  initial begin
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      if (hold_output) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_output = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 10);
        if (wait_cycles > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_request(input tki_pkg::op_e op, input logic [ScoreW-1:0] score,
                              input logic [PayloadW-1:0] payload,
                              input logic [IdxW-1:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    score_i <= score;
    payload_i <= payload;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // mix of wide-range scores, scores around the cutoff, ties and extremes
  function automatic logic [ScoreW-1:0] pick_score();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: return board.cutoff() + $urandom_range(0, 2) - 1;
      6, 7: return board.score_at($urandom_range(0, ListSize - 1));
      8: return $urandom_range(0, 15);
      9: return '1 - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [PayloadW-1:0] pl;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // cleared list, zero score rejected, ties at top and bottom, ignored fields
    send_request(tki_pkg::OP_READ, '1, '1, 6'd0);
    send_request(tki_pkg::OP_READ, '0, '0, 6'd63);
    send_request(tki_pkg::OP_INSERT, '0, '1, 6'd0);
    send_request(tki_pkg::OP_INSERT, 32'd1, '1, '1);
    send_request(tki_pkg::OP_INSERT, '1, '0, 6'd0);
    send_request(tki_pkg::OP_INSERT, '1, 64'h5555_5555_5555_5555, 6'd21);
    send_request(tki_pkg::OP_INSERT, 32'd1, 64'hAAAA_AAAA_AAAA_AAAA, 6'd42);
    send_request(tki_pkg::OP_INSERT, 32'd7, 64'h0123_4567_89AB_CDEF, 6'd0);
    send_request(tki_pkg::OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001, 6'd0);
    for (int i = 0; i < 6; i++) send_request(tki_pkg::OP_READ, '1, '1, 6'(i));
    send_request(tki_pkg::OP_READ, '0, '0, 6'd62);
    send_request(tki_pkg::OP_READ, '1, '1, 6'd63);
    send_request(tki_pkg::OP_READ, '0, '0, 6'd5);

    for (int n = 0; n < int'(RandomItems); n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (n == 150) begin
        // keep offering requests while the output is held off
        no_idle = 1'b1;
        hold_output = 1'b1;
      end
      pl = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 60) begin
        send_request(tki_pkg::OP_INSERT, pick_score(), pl, 6'($urandom_range(0, 63)));
      end else begin
        send_request(tki_pkg::OP_READ, $urandom, pl, 6'($urandom_range(0, 63)));
      end
    end
    in_valid_i <= 1'b0;

    // let the monitor note the last request before counting what is pending
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tki_pkg.sv
hdl/tki_cell.sv
hdl/tki_chain.sv
hdl/top_k_sorted_insert_unit.sv
hdl/tki_checker.sv
sim/testbench.sv
